[rtl/dlm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlm_pkg
// Shared constants, codes and types of the dense layer multiply-accumulate core.
// ---------------------------------------------------------------------------
package dlm_pkg;

	localparam int PIXELS  = 784;
	localparam int NEURONS = 10;

	localparam int OP_W    = 2;
	localparam int NEUR_W  = 4;
	localparam int PIX_W   = 10;
	localparam int VALUE_W = 32;
	localparam int Q_W     = 16;
	localparam int PROD_W  = 2 * Q_W;
	localparam int SUM_W   = 48;

	localparam int NIDX_W  = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int WDEPTH  = NEURONS * PIXELS;
	localparam int WADDR_W = $clog2(WDEPTH);

	localparam logic [OP_W-1:0] OP_WEIGHT = 2'd0;
	localparam logic [OP_W-1:0] OP_BIAS   = 2'd1;
	localparam logic [OP_W-1:0] OP_PIXEL  = 2'd2;

	typedef struct packed {
		logic              issue;
		logic [NIDX_W-1:0] issue_idx;
		logic              emit;
		logic [NIDX_W-1:0] emit_idx;
		logic              bias_wr;
		logic [NIDX_W-1:0] bias_idx;
	} mac_cmd_t;

	function automatic logic [WADDR_W-1:0] waddr(input logic [NIDX_W-1:0] n,
			input logic [PIX_W-1:0] p);
		waddr = WADDR_W'(n) * WADDR_W'(PIXELS) + WADDR_W'(p);
	endfunction

endpackage

[rtl/dlm_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlm_ram
// Single write port, single registered read port memory.
// ---------------------------------------------------------------------------
module dlm_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/dlm_mac.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlm_mac
// Shared multiply-accumulate unit with bias and accumulator register files.
// ---------------------------------------------------------------------------
module dlm_mac (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dlm_pkg::mac_cmd_t               cmd,
	input  logic signed [dlm_pkg::Q_W-1:0]  pixel,
	input  logic signed [dlm_pkg::Q_W-1:0]  weight,
	input  logic [dlm_pkg::VALUE_W-1:0]     bias_data,
	output logic [dlm_pkg::SUM_W-1:0]       sum,
	output logic                            busy
);

	import dlm_pkg::*;

	logic                     vld_s1;
	logic [NIDX_W-1:0]        idx_s1;
	logic                     vld_s2;
	logic [NIDX_W-1:0]        idx_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic [VALUE_W-1:0] bias_q [NEURONS];
	logic [SUM_W-1:0]   acc_q  [NEURONS];

	logic [NIDX_W-1:0] sel;
	logic [SUM_W-1:0]  addend;
	logic [VALUE_W-1:0] bias_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= cmd.issue_idx;
		idx_s2  <= idx_s1;
		prod_s2 <= pixel * weight;
		if (cmd.bias_wr) begin
			bias_q[cmd.bias_idx] <= bias_data;
		end
	end

	// one adder serves accumulation and the bias add on readout
	assign sel      = cmd.emit ? cmd.emit_idx : idx_s2;
	assign bias_sel = bias_q[cmd.emit_idx];
	assign addend   = cmd.emit ? {{(SUM_W-VALUE_W){bias_sel[VALUE_W-1]}}, bias_sel}
	                           : {{(SUM_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign sum      = acc_q[sel] + addend;
	assign busy     = vld_s1 | vld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NEURONS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (cmd.emit) begin
			acc_q[sel] <= '0;
		end else if (vld_s2) begin
			acc_q[sel] <= sum;
		end
	end

endmodule

[rtl/dense_layer_mac_core.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dense_layer_mac_core
// Fully connected layer: weight/bias loads, per-pixel multiply-accumulate
// over all neurons, and bias-added sums read out at the end of each image.
// ---------------------------------------------------------------------------
//  channel | signals                                     | dir
//  in      | in_valid in_ready op neuron pixel_index value | in
//  out     | out_valid out_ready out_neuron sum_value     | out
//          | last_of_run                                  |
//
//  weight and bias loads leave the core ready for the next item
//  a pixel steps through all neurons: the weight memory read port and the
//  shared multiply-accumulate handle one neuron per cycle, then the pipeline drains
//  the final pixel of an image is followed by a readout of NEURONS results,
//  one per cycle, slower when out_ready is held low
//  reset clears the accumulators and all control state; stores start undefined
// ---------------------------------------------------------------------------
module dense_layer_mac_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dlm_pkg::OP_W-1:0]          op,
	input  logic [dlm_pkg::NEUR_W-1:0]        neuron,
	input  logic [dlm_pkg::PIX_W-1:0]         pixel_index,
	input  logic signed [dlm_pkg::VALUE_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dlm_pkg::NEUR_W-1:0]        out_neuron,
	output logic signed [dlm_pkg::SUM_W-1:0]  sum_value,
	output logic                              last_of_run
);

	import dlm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]        state_q;
	logic [NIDX_W-1:0] cnt_q;
	logic [PIX_W-1:0]  pix_q;
	logic [Q_W-1:0]    px_q;
	logic              last_q;

	logic              in_xfer;
	logic              neur_ok;
	logic              pix_ok;
	logic              wr_weight;
	logic              cnt_end;
	logic              emit_go;
	logic              busy;
	logic [Q_W-1:0]    rd_data;
	logic [SUM_W-1:0]  sum;
	mac_cmd_t          cmd;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid & in_ready;
	assign neur_ok   = (neuron < NEUR_W'(NEURONS));
	assign pix_ok    = (pixel_index < PIX_W'(PIXELS));
	assign wr_weight = in_xfer & (op == OP_WEIGHT) & neur_ok & pix_ok;
	assign cnt_end   = (cnt_q == NIDX_W'(NEURONS - 1));
	assign emit_go   = (state_q == ST_EMIT) & (~out_valid | out_ready);

	always_comb begin
		cmd           = '0;
		cmd.issue     = (state_q == ST_MAC);
		cmd.issue_idx = cnt_q;
		cmd.emit      = emit_go;
		cmd.emit_idx  = cnt_q;
		cmd.bias_wr   = in_xfer & (op == OP_BIAS) & neur_ok;
		cmd.bias_idx  = neuron[NIDX_W-1:0];
	end

	dlm_ram #(
		.DEPTH (WDEPTH),
		.WIDTH (Q_W)
	) u_weight_ram (
		.clk     (clk),
		.wr_en   (wr_weight),
		.wr_addr (waddr(neuron[NIDX_W-1:0], pixel_index)),
		.wr_data (value[Q_W-1:0]),
		.rd_en   (cmd.issue),
		.rd_addr (waddr(cnt_q, pix_q)),
		.rd_data (rd_data)
	);

	dlm_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pixel     (px_q),
		.weight    (rd_data),
		.bias_data (value),
		.sum       (sum),
		.busy      (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && op == OP_PIXEL && pix_ok) begin
						last_q  <= (pixel_index == PIX_W'(PIXELS - 1));
						cnt_q   <= '0;
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (cnt_end) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!busy) begin
						cnt_q   <= '0;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (cnt_end) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_q <= pixel_index;
			px_q  <= value[Q_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_neuron  <= NEUR_W'(cnt_q);
			sum_value   <= sum;
			last_of_run <= cnt_end;
		end
	end

endmodule

[rtl/dlm_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dlm_checker
// Port-level checks of the dense layer core, bound to the top level.
// ---------------------------------------------------------------------------
module dlm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [dlm_pkg::OP_W-1:0]          op,
	input logic [dlm_pkg::PIX_W-1:0]         pixel_index,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [dlm_pkg::NEUR_W-1:0]        out_neuron,
	input logic signed [dlm_pkg::SUM_W-1:0]  sum_value,
	input logic                              last_of_run
);

	import dlm_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sum_value) && $stable(out_neuron))
		else $error("result changed while stalled");

	a_neuron_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_neuron < NEUR_W'(NEURONS))
		else $error("result neuron out of range");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_run == (out_neuron == NEUR_W'(NEURONS - 1))))
		else $error("last flag on wrong neuron");

	// a valid pixel keeps the core busy
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_PIXEL && pixel_index < PIX_W'(PIXELS)
		|=> !in_ready)
		else $error("ready after pixel transfer");

	// the core stays ready after a load
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (op == OP_WEIGHT || op == OP_BIAS) |=> in_ready)
		else $error("not ready after load transfer");

endmodule

bind dense_layer_mac_core dlm_checker u_dlm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.op          (op),
	.pixel_index (pixel_index),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.out_neuron  (out_neuron),
	.sum_value   (sum_value),
	.last_of_run (last_of_run)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for dense_layer_mac_core. Weight and bias loads and
// pixel transfers are mirrored in a local copy of the layer. Every pixel at
// the last index yields one expected sum per neuron. The output channel is
// checked in order against those sums. Images use only pixel indices whose
// weights are all loaded. Traffic runs with and without random idling on
// both sides, a long output stall, and pauses until the output is drained.
// ---------------------------------------------------------------------------
module tb;
	import dlm_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [NEUR_W-1:0] nrn;
		logic [SUM_W-1:0]  sum;
		logic              last;
	} neuron_sum_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [OP_W-1:0]            op = '0;
	logic [NEUR_W-1:0]          neuron = '0;
	logic [PIX_W-1:0]           pixel_index = '0;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [NEUR_W-1:0]          out_neuron;
	logic signed [SUM_W-1:0]    sum_value;
	logic                       last_of_run;

	logic [Q_W-1:0]     weight_copy [NEURONS*PIXELS];
	bit                 weight_known [NEURONS*PIXELS];
	logic [VALUE_W-1:0] bias_copy [NEURONS];
	logic [SUM_W-1:0]   layer_acc [NEURONS];
	bit                 pix_loaded [PIXELS];
	int                 loaded_pix [$];
	neuron_sum_t        sums_due [$];

	int effective_items = 0;
	int mismatch_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int hold_req = 0;
	int hold_seen = 0;

	dense_layer_mac_core DUT (.*);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [SUM_W-1:0] got,
			input logic [SUM_W-1:0] want);
		if (mismatch_count < 100)
			$display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
		mismatch_count++;
	endtask

	// mirror of the layer: loads, accumulation and end-of-image sums
	task automatic accumulate_item(input logic [OP_W-1:0] o, input logic [NEUR_W-1:0] n,
			input logic [PIX_W-1:0] p, input logic [VALUE_W-1:0] v);
		logic signed [2*Q_W-1:0] prod;
		neuron_sum_t r;
		bit full;
		int k;
		if (o == OP_WEIGHT) begin
			if (n < NEURONS && p < PIXELS) begin
				weight_copy[n*PIXELS + p] = v[Q_W-1:0];
				weight_known[n*PIXELS + p] = 1'b1;
				effective_items++;
				full = 1'b1;
				for (k = 0; k < NEURONS; k++)
					if (!weight_known[k*PIXELS + p])
						full = 1'b0;
				if (full && !pix_loaded[p]) begin
					pix_loaded[p] = 1'b1;
					loaded_pix.push_back(p);
				end
			end
		end else if (o == OP_BIAS) begin
			if (n < NEURONS) begin
				bias_copy[n] = v;
				effective_items++;
			end
		end else if (o == OP_PIXEL && p < PIXELS) begin
			effective_items++;
			for (k = 0; k < NEURONS; k++) begin
				prod = $signed(v[Q_W-1:0]) * $signed(weight_copy[k*PIXELS + p]);
				layer_acc[k] = layer_acc[k] + {{(SUM_W-2*Q_W){prod[2*Q_W-1]}}, prod};
			end
			if (p == PIXELS - 1) begin
				for (k = 0; k < NEURONS; k++) begin
					r.nrn = NEUR_W'(k);
					r.sum = layer_acc[k] +
						{{(SUM_W-VALUE_W){bias_copy[k][VALUE_W-1]}}, bias_copy[k]};
					r.last = (k == NEURONS - 1);
					sums_due.push_back(r);
					layer_acc[k] = '0;
				end
			end
		end
	endtask

	// one input transfer; called right after a rising edge
	task automatic send_item(input logic [OP_W-1:0] o, input logic [NEUR_W-1:0] n,
			input logic [PIX_W-1:0] p, input logic [VALUE_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		neuron <= n;
		pixel_index <= p;
		value <= v;
		do @(posedge clk); while (in_ready !== 1'b1);
		accumulate_item(o, n, p, v);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_image_run(input int body_len);
		logic [PIX_W-1:0] p;
		int k;
		for (k = 0; k < body_len; k++) begin
			p = PIX_W'(loaded_pix[$urandom_range(loaded_pix.size() - 1)]);
			if ($urandom_range(99) < 15) begin
				if ($urandom_range(1))
					send_item(OP_WEIGHT, NEUR_W'($urandom_range(NEURONS - 1)), p,
						$urandom());
				else
					send_item(OP_BIAS, NEUR_W'($urandom_range(NEURONS - 1)), '0,
						$urandom());
			end else begin
				send_item(OP_PIXEL, NEUR_W'($urandom_range(15)), p, $urandom());
			end
		end
		send_item(OP_PIXEL, NEUR_W'($urandom_range(15)), PIX_W'(PIXELS - 1), $urandom());
	endtask

	task automatic send_noise();
		logic [OP_W-1:0] o;
		logic [PIX_W-1:0] p;
		o = OP_W'($urandom_range(3));
		p = PIX_W'($urandom_range(1023));
		// never read weights that were not loaded
		if (o == OP_PIXEL && p < PIXELS && !pix_loaded[p])
			p = PIX_W'(PIXELS + $urandom_range(1023 - PIXELS));
		send_item(o, NEUR_W'($urandom_range(15)), p, $urandom());
	endtask

	task automatic test_preload();
		logic [PIX_W-1:0] p;
		int k, j;
		send_item(OP_BIAS, 0, '0, 32'h7FFF_FFFF);
		send_item(OP_BIAS, 1, '0, 32'h8000_0000);
		send_item(OP_BIAS, 2, '0, 32'h0000_0000);
		send_item(OP_BIAS, 3, '0, 32'hFFFF_FFFF);
		for (k = 4; k < NEURONS; k++)
			send_item(OP_BIAS, NEUR_W'(k), '0, $urandom());
		for (k = 0; k < NEURONS; k++) begin
			send_item(OP_WEIGHT, NEUR_W'(k), 0,
				{16'($urandom_range(16'hFFFF)), (k % 2) ? 16'h8000 : 16'h7FFF});
			send_item(OP_WEIGHT, NEUR_W'(k), PIX_W'(PIXELS - 1),
				{16'($urandom_range(16'hFFFF)), (k % 2) ? 16'h7FFF : 16'h8000});
		end
		for (j = 0; j < 4; j++) begin
			p = PIX_W'($urandom_range(1, PIXELS - 2));
			for (k = 0; k < NEURONS; k++)
				send_item(OP_WEIGHT, NEUR_W'(k), p, $urandom());
		end
	endtask

	task automatic test_special_cases();
		send_item(OP_UNUSED, NEUR_W'($urandom_range(15)), PIX_W'(PIXELS - 1), $urandom());
		send_item(OP_BIAS, 15, '0, $urandom());
		send_item(OP_BIAS, NEUR_W'(NEURONS), '0, $urandom());
		send_item(OP_WEIGHT, 15, 0, $urandom());
		send_item(OP_WEIGHT, 0, 10'h3FF, $urandom());
		send_item(OP_WEIGHT, 1, PIX_W'(PIXELS), $urandom());
		send_item(OP_PIXEL, 0, 10'h3FF, $urandom());
		send_item(OP_PIXEL, 0, PIX_W'(PIXELS), $urandom());
		// repeated index, extreme products
		send_item(OP_PIXEL, 15, 0, {16'($urandom_range(16'hFFFF)), 16'h8000});
		send_item(OP_PIXEL, 0, 0, {16'($urandom_range(16'hFFFF)), 16'h7FFF});
		send_item(OP_PIXEL, 0, PIX_W'(PIXELS - 1), {16'hFFFF, 16'h8000});
		send_item(OP_PIXEL, 0, 0, 32'h0);
		send_item(OP_PIXEL, 0, PIX_W'(PIXELS - 1), 32'hFFFF_FFFF);
		wait_for_drain();
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int count);
		int target;
		idle_pct = idle;
		stall_pct <= stall;
		target = effective_items + count;
		while (effective_items < target) begin
			if ($urandom_range(99) < 20)
				send_noise();
			else
				send_image_run($urandom_range(1, 6));
		end
		wait_for_drain();
	endtask

	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct <= 0;
		hold_req = hold_req + 1;
		repeat (3) send_image_run(3);
		wait_for_drain();
	endtask

	task automatic test_drain_pause();
		idle_pct = 0;
		stall_pct <= 30;
		repeat (4) begin
			send_image_run($urandom_range(1, 4));
			wait_for_drain();
		end
	endtask

	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		neuron_sum_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (sums_due.size() == 0) begin
				report_mismatch("unexpected transfer", sum_value, '0);
			end else begin
				want = sums_due.pop_front();
				if (out_neuron !== want.nrn)
					report_mismatch("out_neuron", out_neuron, want.nrn);
				if (sum_value !== want.sum)
					report_mismatch("sum_value", sum_value, want.sum);
				if (last_of_run !== want.last)
					report_mismatch("last_of_run", last_of_run, want.last);
			end
		end
	end

	initial begin
		int k;
		for (k = 0; k < NEURONS; k++)
			layer_acc[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_preload();
		test_special_cases();
		test_random_traffic(0, 0, 60);
		test_random_traffic(70, 0, 60);
		test_random_traffic(0, 70, 60);
		test_random_traffic(15, 15, 60);
		test_backpressure();
		test_drain_pause();
		wait_for_drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
